/* hdl/atrp_pkg.sv */
// atrp_pkg: widths, angle constants, arctangent table and grid rounding
// for the accelerometer tilt pipeline; no dependencies
`default_nettype none

package atrp_pkg;

    localparam int X_W             = 16;
    localparam int CPG_W           = 13;
    localparam int ROLL_W          = 16;
    localparam int PITCH_W         = 15;
    localparam int ANGLE_FRAC_BITS = 7;
    localparam int CORDIC_STAGES   = 16;
    localparam int TABLE_LEN       = 24;
    localparam int INT_FRAC        = 24;
    localparam int OUT_SHIFT       = INT_FRAC - ANGLE_FRAC_BITS;

    // square root operand: (c*c - x*x) << 32
    localparam int SQ_W     = 2 * CPG_W;
    localparam int VW       = SQ_W + 32;
    localparam int SQ_STEPS = VW / 2;

    // cordic vector and angle accumulator widths
    localparam int CW = 36;
    localparam int AW = 34;

    localparam int SIDE_DLY = SQ_STEPS + 1 + CORDIC_STAGES;
    localparam int LATENCY  = SQ_STEPS + CORDIC_STAGES + 4;

    localparam logic signed [AW-1:0] DEG180 = AW'(64'sd180 <<< INT_FRAC);
    localparam logic signed [AW-1:0] DEG90  = AW'(64'sd90 <<< INT_FRAC);
    localparam logic signed [AW-1:0] HALF_LSB = AW'(64'sd1 <<< (OUT_SHIFT - 1));

    localparam logic signed [PITCH_W-1:0] PITCH_FULL = PITCH_W'(90 << ANGLE_FRAC_BITS);
    localparam logic signed [ROLL_W-1:0]  ROLL_FULL  = ROLL_W'(180 << ANGLE_FRAC_BITS);

    // atan(2^-i) in degrees, 24 fraction bits
    localparam logic [AW-1:0] ATAN_TAB [TABLE_LEN] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115
    };

    // clamp to +-lim, add half an output step, floor to the output grid
    function automatic logic signed [AW-1:0] to_grid(
        input logic signed [AW-1:0] a,
        input logic signed [AW-1:0] lim
    );
        logic signed [AW-1:0] c;
        c = a;
        if (a > lim)
            c = lim;
        if (a < -lim)
            c = -lim;
        return (c + HALF_LSB) >>> OUT_SHIFT;
    endfunction

endpackage

`default_nettype wire

/* hdl/accel_tilt_roll_pitch_top.sv */
// accel_tilt_roll_pitch_top: roll and pitch tilt angles from a raw
// three-axis accelerometer beat; uses atrp_pkg, atrp_isqrt, atrp_cordic
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------------
//   sample   | start / busy           | x_accel, y_accel, z_accel (s16)
//   result   | done (one-cycle strobe)| roll_angle s16, pitch_angle s15,
//            |                        | pitch_clipped
//   config   | cfg_wr_en              | cfg_wr_data = counts_per_g (u13)
//
// one beat accepted every cycle; busy is always low
// pipeline: 2 prep stages, 29 square root stages (one root bit each),
// 1 fold stage and 16 cordic stages, 1 rounding stage
// roll runs its own cordic beside the square root and waits in a delay line
// rst_n clears valid bits and sets counts_per_g to 256; data regs are not reset
// the pipeline never stalls, the receiver takes each done beat as it comes
`default_nettype none

module accel_tilt_roll_pitch_top
    import atrp_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic signed [X_W-1:0]     x_accel,
    input  wire logic signed [X_W-1:0]     y_accel,
    input  wire logic signed [X_W-1:0]     z_accel,
    input  wire logic                      cfg_wr_en,
    input  wire logic [CPG_W-1:0]          cfg_wr_data,
    output logic                           done,
    output logic signed [ROLL_W-1:0]       roll_angle,
    output logic signed [PITCH_W-1:0]      pitch_angle,
    output logic                           pitch_clipped
);

    // side info for pitch, carried alongside the square root and cordic
    typedef struct packed {
        logic normal;   // |x| < one g, use the cordic
        logic neg;      // sign of x
        logic clip;     // |x| > one g
    } side_t;

    logic [CPG_W-1:0] cpg_reg;

    // stage 1: captured sample
    logic                  s1_vld_reg;
    logic signed [X_W-1:0] x_s1_reg, y_s1_reg, z_s1_reg;
    logic [CPG_W-1:0]      c_s1_reg;

    // stage 2: squares and flags
    logic [X_W-1:0]        ax;
    logic                  s2_vld_reg;
    logic signed [X_W-1:0] x_s2_reg, y_s2_reg, z_s2_reg;
    logic [SQ_W-1:0]       csq_reg, xsq_reg;
    side_t                 side_next, side_s2_reg;

    logic [SQ_W-1:0]       rem;
    logic                  sq_valid;
    logic [SQ_STEPS-1:0]   sq_root;

    logic signed [X_W-1:0] x_dly_reg [SQ_STEPS];
    side_t                 side_dly_reg [SIDE_DLY];
    logic signed [AW-1:0]  roll_dly_reg [SQ_STEPS];

    logic signed [AW-1:0]  roll_raw, pitch_raw, pitch_sel;
    logic                  pitch_valid;
    logic signed [AW-1:0]  roll_grid, pitch_grid;
    side_t                 side_out;

    logic                         done_reg;
    logic signed [ROLL_W-1:0]     roll_reg;
    logic signed [PITCH_W-1:0]    pitch_reg;
    logic                         clip_reg;

    assign busy = 1'b0;

    // counts_per_g register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cpg_reg <= CPG_W'(256);
        else if (cfg_wr_en)
            cpg_reg <= cfg_wr_data;
    end

    // valid bits of the prep stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= start && !busy;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    // stage 1: capture, zero scale taken as one
    always_ff @(posedge clk)
    begin
        x_s1_reg <= x_accel;
        y_s1_reg <= y_accel;
        z_s1_reg <= z_accel;
        c_s1_reg <= (cpg_reg == '0) ? CPG_W'(1) : cpg_reg;
    end

    // stage 2: |x| against one g, both squares
    assign ax = x_s1_reg[X_W-1] ? X_W'(-x_s1_reg) : X_W'(x_s1_reg);

    always_comb
    begin
        side_next.neg    = x_s1_reg[X_W-1];
        side_next.clip   = ax > X_W'(c_s1_reg);
        side_next.normal = ax < X_W'(c_s1_reg);
    end

    always_ff @(posedge clk)
    begin
        x_s2_reg    <= x_s1_reg;
        y_s2_reg    <= y_s1_reg;
        z_s2_reg    <= z_s1_reg;
        side_s2_reg <= side_next;
        csq_reg     <= SQ_W'(c_s1_reg) * SQ_W'(c_s1_reg);
        xsq_reg     <= SQ_W'(ax[CPG_W-1:0]) * SQ_W'(ax[CPG_W-1:0]);
    end

    // sqrt((c*c - x*x) << 32), only meaningful when |x| < one g
    assign rem = csq_reg - xsq_reg;

    atrp_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_vld_reg),
        .in_val    ({rem, 32'b0}),
        .out_valid (sq_valid),
        .out_root  (sq_root)
    );

    // roll = atan2(y, z), started right after the prep stages
    atrp_cordic u_roll_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_vld_reg),
        .in_num    ({{(CW-X_W-16){y_s2_reg[X_W-1]}}, y_s2_reg, 16'b0}),
        .in_den    ({{(CW-X_W-16){z_s2_reg[X_W-1]}}, z_s2_reg, 16'b0}),
        .out_valid (),
        .out_angle (roll_raw)
    );

    // pitch = atan2(x, sqrt(c*c - x*x)), i.e. asin(x / c)
    atrp_cordic u_pitch_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_num    ({{(CW-X_W-16){x_dly_reg[SQ_STEPS-1][X_W-1]}},
                     x_dly_reg[SQ_STEPS-1], 16'b0}),
        .in_den    ({{(CW-SQ_STEPS){1'b0}}, sq_root}),
        .out_valid (pitch_valid),
        .out_angle (pitch_raw)
    );

    // delay lines: x waits for the root, roll and flags wait for pitch
    always_ff @(posedge clk)
    begin
        x_dly_reg[0]    <= x_s2_reg;
        roll_dly_reg[0] <= roll_raw;
        side_dly_reg[0] <= side_s2_reg;
        for (int k = 1; k < SQ_STEPS; k++)
        begin
            x_dly_reg[k]    <= x_dly_reg[k-1];
            roll_dly_reg[k] <= roll_dly_reg[k-1];
        end
        for (int k = 1; k < SIDE_DLY; k++)
            side_dly_reg[k] <= side_dly_reg[k-1];
    end

    // rounding to the output grid, full-scale pitch when |x| reaches or exceeds one g
    assign side_out  = side_dly_reg[SIDE_DLY-1];
    assign pitch_sel = side_out.normal ? pitch_raw : (side_out.neg ? -DEG90 : DEG90);
    assign roll_grid  = to_grid(roll_dly_reg[SQ_STEPS-1], DEG180);
    assign pitch_grid = to_grid(pitch_sel, DEG90);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= pitch_valid;
    end

    always_ff @(posedge clk)
    begin
        roll_reg  <= roll_grid[ROLL_W-1:0];
        pitch_reg <= pitch_grid[PITCH_W-1:0];
        clip_reg  <= side_out.clip;
    end

    assign done          = done_reg;
    assign roll_angle    = roll_reg;
    assign pitch_angle   = pitch_reg;
    assign pitch_clipped = clip_reg;

`ifndef SYNTHESIS
    // every result beat traces back to a sample accepted a fixed time before
    a_done_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result beat without a matching sample beat");

    // a clipped pitch sits on the rail
    a_clip_on_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (done && pitch_clipped) |->
            (pitch_angle == PITCH_FULL || pitch_angle == -PITCH_FULL))
        else $error("clipped pitch not saturated");

    // roll stays within half a turn
    a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (roll_angle <= ROLL_FULL && roll_angle >= -ROLL_FULL))
        else $error("roll outside half a turn");
`endif

endmodule

`default_nettype wire

/* hdl/atrp_isqrt.sv */
// atrp_isqrt: pipelined restoring integer square root, one result bit per stage
// depends on atrp_pkg
`default_nettype none

module atrp_isqrt
    import atrp_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic [VW-1:0]       in_val,
    output logic                     out_valid,
    output logic [SQ_STEPS-1:0]      out_root
);

    logic [VW-1:0]       v_reg [SQ_STEPS];
    logic [VW:0]         r_reg [SQ_STEPS];
    logic [VW-1:0]       v_next [SQ_STEPS];
    logic [VW:0]         r_next [SQ_STEPS];
    logic [SQ_STEPS-1:0] vld_reg;

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
        localparam logic [VW:0] BIT_K = (VW+1)'(1) << (2 * (SQ_STEPS - 1 - k));
        logic [VW-1:0] v_prev;
        logic [VW:0]   r_prev;
        logic [VW:0]   sum;
        logic          take;

        if (k == 0) begin : g_first
            assign v_prev = in_val;
            assign r_prev = '0;
        end
        else begin : g_rest
            assign v_prev = v_reg[k-1];
            assign r_prev = r_reg[k-1];
        end

        assign sum       = r_prev + BIT_K;
        assign take      = {1'b0, v_prev} >= sum;
        assign v_next[k] = take ? (v_prev - sum[VW-1:0]) : v_prev;
        assign r_next[k] = take ? ((r_prev >> 1) + BIT_K) : (r_prev >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[SQ_STEPS-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < SQ_STEPS; k++)
        begin
            v_reg[k] <= v_next[k];
            r_reg[k] <= r_next[k];
        end
    end

    assign out_valid = vld_reg[SQ_STEPS-1];
    assign out_root  = r_reg[SQ_STEPS-1][SQ_STEPS-1:0];

endmodule

`default_nettype wire

/* hdl/atrp_cordic.sv */
// atrp_cordic: pipelined vectoring cordic giving atan2(num, den) in degrees
// with 24 fraction bits; depends on atrp_pkg
`default_nettype none

module atrp_cordic
    import atrp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic signed [CW-1:0] in_num,
    input  wire logic signed [CW-1:0] in_den,
    output logic                      out_valid,
    output logic signed [AW-1:0]      out_angle
);

    localparam int N = CORDIC_STAGES;

    logic signed [CW-1:0] x_reg [N+1];
    logic signed [CW-1:0] y_reg [N+1];
    logic signed [AW-1:0] a_reg [N+1];
    logic                 h_reg [N+1];
    logic signed [CW-1:0] x_next [N+1];
    logic signed [CW-1:0] y_next [N+1];
    logic signed [AW-1:0] a_next [N+1];
    logic                 h_next [N+1];
    logic [N:0]           vld_reg;
    logic                 num_zero;
    logic                 fold;

    // quadrant fold; a zero numerator holds the axis angle through all stages
    assign num_zero  = (in_num == '0);
    assign fold      = !num_zero && in_den[CW-1];
    assign x_next[0] = fold ? -in_den : in_den;
    assign y_next[0] = fold ? -in_num : in_num;
    assign h_next[0] = num_zero;
    assign a_next[0] = num_zero ? (in_den[CW-1] ? DEG180 : '0)
                     : (fold ? (in_num[CW-1] ? -DEG180 : DEG180) : '0);

    for (genvar i = 0; i < N; i++) begin : g_stage
        logic                 neg_y;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [AW-1:0] step;

        assign neg_y = y_reg[i][CW-1];
        assign dx    = y_reg[i] >>> i;
        assign dy    = x_reg[i] >>> i;
        assign step  = $signed(ATAN_TAB[i]);

        assign x_next[i+1] = neg_y ? (x_reg[i] - dx) : (x_reg[i] + dx);
        assign y_next[i+1] = neg_y ? (y_reg[i] + dy) : (y_reg[i] - dy);
        assign a_next[i+1] = h_reg[i] ? a_reg[i]
                           : (neg_y ? (a_reg[i] - step) : (a_reg[i] + step));
        assign h_next[i+1] = h_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[N-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i <= N; i++)
        begin
            x_reg[i] <= x_next[i];
            y_reg[i] <= y_next[i];
            a_reg[i] <= a_next[i];
            h_reg[i] <= h_next[i];
        end
    end

    assign out_valid = vld_reg[N];
    assign out_angle = a_reg[N];

endmodule

`default_nettype wire
